// ----- rtl/core/wdt_pkg.sv -----
// ---------------------------------------------------------------------------
// Watchdog timer package
// Register offsets, lock keys, field widths and opcodes shared by the
// channel interfaces and the watchdog core.
// ---------------------------------------------------------------------------
package wdt_pkg;

    // Field widths of one transaction
    localparam int OFFSET_W = 12;
    localparam int DATA_W   = 32;

    // Default width of the countdown and of the stored reload value
    localparam int COUNT_WIDTH_DEF = 32;

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register byte offsets
    localparam logic [OFFSET_W-1:0] OFF_LOAD   = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_CTL    = 12'h008;
    localparam logic [OFFSET_W-1:0] OFF_INTCLR = 12'h00c;
    localparam logic [OFFSET_W-1:0] OFF_LOCK   = 12'hc00;

    // Lock register keys
    localparam logic [DATA_W-1:0] KEY_UNLOCK = 32'h1acce551;
    localparam logic [DATA_W-1:0] KEY_LOCK   = 32'h00000001;

    // CTL bit positions
    localparam int CTL_INTEN_BIT = 0;
    localparam int CTL_RESEN_BIT = 1;

endpackage

// ----- rtl/core/wdt_if.sv -----
// ---------------------------------------------------------------------------
// Watchdog channel interfaces
// Valid/ready channels for incoming ticks and register writes, and for the
// per-transaction status results.
// ---------------------------------------------------------------------------
interface wdt_in_if
    import wdt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [OFFSET_W-1:0] reg_offset;
    logic [DATA_W-1:0]   wdata;

    modport source (output valid, op, reg_offset, wdata, input ready);
    modport sink (input valid, op, reg_offset, wdata, output ready);
    modport monitor (input valid, ready, op, reg_offset, wdata);
endinterface

interface wdt_out_if;
    logic valid;
    logic ready;
    logic irq_raised;
    logic reset_request;
    logic write_rejected;
    logic irq_pending;

    modport source (output valid, irq_raised, reset_request, write_rejected, irq_pending,
                    input ready);
    modport sink (input valid, irq_raised, reset_request, write_rejected, irq_pending,
                  output ready);
    modport monitor (input valid, ready, irq_raised, reset_request, write_rejected,
                     irq_pending);
endinterface

// ----- rtl/core/watchdog_timer_registers_unit.sv -----
// ---------------------------------------------------------------------------
// Watchdog timer with register interface
// Countdown watchdog driven by tick and register-write transactions.
// ---------------------------------------------------------------------------
// Each input transaction is either one timer tick or one register write
// (LOAD, CTL, INTCLR, LOCK). Unless the output stalls, the block takes one
// transaction per clock and returns exactly one status result for it in the
// next cycle from an output register; the single pass of next-state logic
// between the watchdog state registers and that output register sets this
// rate. Input is accepted whenever the output register is empty or is
// being drained in the same cycle. The countdown period is the low
// COUNT_WIDTH bits of LOAD, with 0 counted as 1, sampled at countdown start.
module watchdog_timer_registers_unit
    import wdt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    wdt_in_if.sink       in_ch,
    wdt_out_if.source    out_ch
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;

    // Watchdog state
    logic                   irq_en_reg,   irq_en_next;
    logic                   res_en_reg,   res_en_next;
    logic                   pending_reg,  pending_next;
    logic                   locked_reg,   locked_next;
    logic                   running_reg,  running_next;
    logic [COUNT_WIDTH-1:0] reload_reg,   reload_next;
    logic [COUNT_WIDTH-1:0] count_reg,    count_next;

    // Output register
    logic out_valid_reg, out_valid_next;
    logic raised_reg, rst_req_reg, rejected_reg, out_pending_reg;

    logic                   accept;
    logic                   raised, rst_req, rejected;
    logic [COUNT_WIDTH-1:0] period;

    // Handshake
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Period sampled at countdown start, zero counts as one
    assign period = (reload_reg == CNT_ZERO) ? CNT_ONE : reload_reg;

    // Next-state and result logic for one transaction
    always_comb
    begin
        irq_en_next  = irq_en_reg;
        res_en_next  = res_en_reg;
        pending_next = pending_reg;
        locked_next  = locked_reg;
        running_next = running_reg;
        reload_next  = reload_reg;
        count_next   = count_reg;
        raised       = 1'b0;
        rst_req      = 1'b0;
        rejected     = 1'b0;

        if (accept)
        begin
            if (in_ch.op == OP_TICK)
            begin
                if (running_reg)
                begin
                    count_next = count_reg - CNT_ONE;
                    // expiry when the count steps from one to zero
                    if (count_reg == CNT_ONE)
                    begin
                        if (pending_reg && res_en_reg)
                        begin
                            rst_req      = 1'b1;
                            running_next = 1'b0;
                        end
                        else if (irq_en_reg)
                        begin
                            raised       = 1'b1;
                            pending_next = 1'b1;
                            count_next   = period;
                        end
                        else
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
            end
            else if (locked_reg && (in_ch.reg_offset != OFF_LOCK))
            begin
                rejected = 1'b1;
            end
            else
            begin
                case (in_ch.reg_offset)
                    OFF_LOAD:
                    begin
                        reload_next = in_ch.wdata[COUNT_WIDTH-1:0];
                    end
                    OFF_CTL:
                    begin
                        // only an enable change touches the countdown
                        if (in_ch.wdata[CTL_INTEN_BIT] != irq_en_reg)
                        begin
                            irq_en_next = in_ch.wdata[CTL_INTEN_BIT];
                            if (in_ch.wdata[CTL_INTEN_BIT])
                            begin
                                count_next   = period;
                                running_next = 1'b1;
                            end
                            else
                            begin
                                pending_next = 1'b0;
                                running_next = 1'b0;
                            end
                        end
                        res_en_next = in_ch.wdata[CTL_RESEN_BIT];
                    end
                    OFF_INTCLR:
                    begin
                        pending_next = 1'b0;
                        count_next   = period;
                        running_next = 1'b1;
                    end
                    OFF_LOCK:
                    begin
                        if (in_ch.wdata == KEY_UNLOCK)
                        begin
                            locked_next = 1'b0;
                        end
                        else if (in_ch.wdata == KEY_LOCK)
                        begin
                            locked_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        // unmapped offset, write ignored
                    end
                endcase
            end
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ch.ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_en_reg    <= 1'b0;
            res_en_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            locked_reg    <= 1'b0;
            running_reg   <= 1'b0;
            reload_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            irq_en_reg    <= irq_en_next;
            res_en_reg    <= res_en_next;
            pending_reg   <= pending_next;
            locked_reg    <= locked_next;
            running_reg   <= running_next;
            reload_reg    <= reload_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded per accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raised_reg      <= raised;
            rst_req_reg     <= rst_req;
            rejected_reg    <= rejected;
            out_pending_reg <= pending_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.irq_raised     = raised_reg;
    assign out_ch.reset_request  = rst_req_reg;
    assign out_ch.write_rejected = rejected_reg;
    assign out_ch.irq_pending    = out_pending_reg;

endmodule

// ----- rtl/core/wdt_checker.sv -----
// ---------------------------------------------------------------------------
// Watchdog port checker
// Concurrent assertions on the watchdog's channel ports, bound to the top.
// ---------------------------------------------------------------------------
module wdt_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic out_valid,
    input  logic out_ready,
    input  logic out_irq_raised,
    input  logic out_reset_request,
    input  logic out_write_rejected,
    input  logic out_irq_pending
);

    // every accepted transaction yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after accepted transaction");

    // a tick never both raises the interrupt and requests reset
    a_expiry_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_irq_raised && out_reset_request))
        else $error("irq and reset request in one result");

    // a rejected write carries no expiry status
    a_reject_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_write_rejected)
            |-> (!out_irq_raised && !out_reset_request))
        else $error("rejected write with expiry status");

    // raising the interrupt leaves it pending
    a_raise_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_irq_raised) |-> out_irq_pending)
        else $error("raised interrupt not pending");

    // stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind watchdog_timer_registers_unit wdt_checker u_wdt_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_irq_raised     (out_ch.irq_raised),
    .out_reset_request  (out_ch.reset_request),
    .out_write_rejected (out_ch.write_rejected),
    .out_irq_pending    (out_ch.irq_pending)
);

// ----- tb/tb_watchdog_timer_registers_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Watchdog timer register unit testbench
// Drives tick and register-write transactions into the watchdog. A directed
// table comes first, then a long random mix of register sequences and writes
// to arbitrary offsets. Every status result is checked against a local model
// of the watchdog state, or a fixed status for some directed rows. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_watchdog_timer_registers_unit;
    import wdt_pkg::*;

    localparam int CW        = COUNT_WIDTH_DEF;
    localparam int RAND_TXNS = 900;
    localparam logic [DATA_W-1:0] PERIOD_MASK =
        (CW >= 32) ? {DATA_W{1'b1}} : ((32'd1 << CW) - 32'd1);

    // One status result, field order as on the output channel
    typedef struct packed {
        logic irq_raised;
        logic reset_request;
        logic write_rejected;
        logic irq_pending;
    } wdt_status_t;

    localparam wdt_status_t ST_QUIET    = 4'b0000;
    localparam wdt_status_t ST_REJECTED = 4'b0010;

    // One row of the directed table
    typedef struct {
        logic                op;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   data;
        bit                  typed;
        wdt_status_t         status;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    wdt_in_if  in_ch ();
    wdt_out_if out_ch ();

    watchdog_timer_registers_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Model of the watchdog state
    logic              wd_ie;
    logic              wd_re;
    logic              wd_pending;
    logic              wd_locked;
    logic [DATA_W-1:0] wd_reload;
    logic [DATA_W-1:0] wd_count;
    logic              wd_running;

    wdt_status_t status_q[$];
    dir_row_t    dir_rows[$];
    int          mismatch_cnt = 0;
    int          sent_cnt     = 0;
    bit          no_idle      = 1'b0;
    int          stall_hold   = 0;

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic check_bit(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    endtask

    // Countdown start: period is LOAD masked to the counter width, 0 means 1
    function automatic void start_countdown();
        logic [DATA_W-1:0] p;
        p = wd_reload & PERIOD_MASK;
        wd_count   = (p == '0) ? 32'd1 : p;
        wd_running = 1'b1;
    endfunction

    // Advance the model by one transaction and return its status
    function automatic wdt_status_t predict_status(input logic op,
                                                   input logic [OFFSET_W-1:0] off,
                                                   input logic [DATA_W-1:0] data);
        wdt_status_t st;
        st = ST_QUIET;
        if (op == OP_TICK)
        begin
            if (wd_running)
            begin
                wd_count = wd_count - 32'd1;
                if (wd_count == '0)
                begin
                    if (wd_pending && wd_re)
                    begin
                        st.reset_request = 1'b1;
                        wd_running = 1'b0;
                    end
                    else if (wd_ie)
                    begin
                        st.irq_raised = 1'b1;
                        wd_pending = 1'b1;
                        start_countdown();
                    end
                    else
                        wd_running = 1'b0;
                end
            end
        end
        else if (wd_locked && off != OFF_LOCK)
            st.write_rejected = 1'b1;
        else if (off == OFF_LOAD)
            wd_reload = data;
        else if (off == OFF_CTL)
        begin
            if (data[CTL_INTEN_BIT] != wd_ie)
            begin
                wd_ie = data[CTL_INTEN_BIT];
                if (wd_ie)
                    start_countdown();
                else
                begin
                    wd_pending = 1'b0;
                    wd_running = 1'b0;
                end
            end
            wd_re = data[CTL_RESEN_BIT];
        end
        else if (off == OFF_INTCLR)
        begin
            wd_pending = 1'b0;
            start_countdown();
        end
        else if (off == OFF_LOCK)
        begin
            if (data == KEY_UNLOCK)
                wd_locked = 1'b0;
            else if (data == KEY_LOCK)
                wd_locked = 1'b1;
        end
        st.irq_pending = wd_pending;
        return st;
    endfunction

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Mostly the defined registers, sometimes any offset
    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return OFF_LOAD;
            1: return OFF_CTL;
            2: return OFF_INTCLR;
            3: return OFF_LOCK;
            default: return OFFSET_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Offer one transaction; on acceptance record the expected status
    task automatic send_txn(input logic op, input logic [OFFSET_W-1:0] off,
                            input logic [DATA_W-1:0] data, input bit typed,
                            input wdt_status_t typed_status);
        int          gap;
        wdt_status_t st;
        gap = idle_draw();
        if (gap > 0)
        begin
            @(negedge clk) in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.reg_offset <= off;
        in_ch.wdata      <= data;
        do
            @(posedge clk);
        while (!in_ch.ready);
        st = predict_status(op, off, data);
        status_q.push_back(typed ? typed_status : st);
        sent_cnt++;
    endtask

    task automatic send_tick();
        send_txn(OP_TICK, OFFSET_W'($urandom_range(0, 4095)), $urandom(), 1'b0, ST_QUIET);
    endtask

    task automatic send_write(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] data);
        send_txn(OP_WRITE, off, data, 1'b0, ST_QUIET);
    endtask

    task automatic add_row(input logic op, input logic [OFFSET_W-1:0] off,
                           input logic [DATA_W-1:0] data, input bit typed,
                           input wdt_status_t status);
        dir_row_t r;
        r.op     = op;
        r.off    = off;
        r.data   = data;
        r.typed  = typed;
        r.status = status;
        dir_rows.push_back(r);
    endtask

    // Result receiver: random stalls, one long hold on request
    initial
    begin
        int          stall;
        wdt_status_t got;
        wdt_status_t want;
        out_ch.ready = 1'b1;
        forever
        begin
            if (stall_hold > 0)
            begin
                stall = stall_hold;
                stall_hold = 0;
            end
            else
                stall = idle_draw();
            if (stall > 0)
            begin
                @(negedge clk) out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk) out_ch.ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
            got.irq_raised     = out_ch.irq_raised;
            got.reset_request  = out_ch.reset_request;
            got.write_rejected = out_ch.write_rejected;
            got.irq_pending    = out_ch.irq_pending;
            if (status_q.size() == 0)
                report_mismatch("status result with no transaction outstanding");
            else
            begin
                want = status_q.pop_front();
                check_bit("irq_raised", got.irq_raised, want.irq_raised);
                check_bit("reset_request", got.reset_request, want.reset_request);
                check_bit("write_rejected", got.write_rejected, want.write_rejected);
                check_bit("irq_pending", got.irq_pending, want.irq_pending);
            end
        end
    end

    // Stimulus
    initial
    begin
        int          r;
        int          n;
        int          drain;
        bit          hold_done;
        bit          pause_done;
        logic [DATA_W-1:0] d;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_TICK;
        in_ch.reg_offset = '0;
        in_ch.wdata      = '0;
        wd_ie      = 1'b0;
        wd_re      = 1'b0;
        wd_pending = 1'b0;
        wd_locked  = 1'b0;
        wd_reload  = '0;
        wd_count   = '0;
        wd_running = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: reset state, expiry paths, extremes, lock handling
        add_row(OP_TICK,  OFF_LOAD,   32'h0,        1'b1, ST_QUIET);
        add_row(OP_WRITE, OFF_CTL,    32'h3,        1'b1, ST_QUIET);
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET); // expiry raises irq
        add_row(OP_TICK,  12'hfff,    32'hffffffff, 1'b0, ST_QUIET); // pending + reset enable
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET); // stopped tick
        add_row(OP_WRITE, OFF_LOAD,   32'hffffffff, 1'b0, ST_QUIET);
        add_row(OP_WRITE, OFF_INTCLR, 32'h0,        1'b0, ST_QUIET);
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET);
        add_row(OP_WRITE, OFF_LOAD,   32'h3,        1'b0, ST_QUIET);
        add_row(OP_WRITE, OFF_CTL,    32'h0,        1'b0, ST_QUIET); // disable clears pending
        add_row(OP_WRITE, OFF_LOCK,   KEY_LOCK,     1'b1, ST_QUIET);
        add_row(OP_WRITE, OFF_LOAD,   32'h5,        1'b1, ST_REJECTED);
        add_row(OP_WRITE, 12'hfff,    32'hffffffff, 1'b1, ST_REJECTED);
        add_row(OP_WRITE, OFF_CTL,    32'h1,        1'b1, ST_REJECTED);
        add_row(OP_WRITE, OFF_LOCK,   32'h12345678, 1'b1, ST_QUIET);    // neither key
        add_row(OP_WRITE, OFF_INTCLR, 32'h0,        1'b1, ST_REJECTED);
        add_row(OP_WRITE, OFF_LOCK,   KEY_UNLOCK,   1'b1, ST_QUIET);
        add_row(OP_WRITE, OFF_CTL,    32'h1,        1'b0, ST_QUIET);
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET);
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET);
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET);
        add_row(OP_WRITE, OFF_CTL,    32'hfffffffd, 1'b0, ST_QUIET); // enable unchanged
        add_row(OP_WRITE, OFF_CTL,    32'h0,        1'b0, ST_QUIET);
        add_row(OP_WRITE, OFF_LOAD,   32'h2,        1'b0, ST_QUIET);
        add_row(OP_WRITE, OFF_INTCLR, 32'h0,        1'b0, ST_QUIET); // restart while disabled
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET);
        add_row(OP_TICK,  12'h000,    32'h0,        1'b0, ST_QUIET); // silent stop
        foreach (dir_rows[i])
            send_txn(dir_rows[i].op, dir_rows[i].off, dir_rows[i].data,
                     dir_rows[i].typed, dir_rows[i].status);
        @(negedge clk) in_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);

        // Random: register sequences with short periods so expiries happen often
        while (sent_cnt < dir_rows.size() + RAND_TXNS)
        begin
            if ($urandom_range(0, 79) == 0)
                no_idle = !no_idle;

            // Long receiver hold while ticks keep coming
            if (!hold_done && sent_cnt > 300)
            begin
                hold_done  = 1'b1;
                no_idle    = 1'b1;
                stall_hold = 250;
                repeat (30) send_tick();
                no_idle = 1'b0;
            end

            // Let everything drain before continuing
            if (!pause_done && sent_cnt > 600)
            begin
                pause_done = 1'b1;
                @(negedge clk) in_ch.valid <= 1'b0;
                while (status_q.size() != 0)
                    @(posedge clk);
            end

            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_tick();
            end
            else if (r < 60)
            begin
                d = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
                send_write(OFF_LOAD, d);
            end
            else if (r < 72)
            begin
                d = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3);
                send_write(OFF_CTL, d);
            end
            else if (r < 80)
                send_write(OFF_INTCLR, $urandom());
            else if (r < 86)
            begin
                // Locked window with a few writes and ticks, then unlock
                send_write(OFF_LOCK, KEY_LOCK);
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_tick();
                    else
                        send_write(pick_offset(), $urandom());
                end
                send_write(OFF_LOCK, KEY_UNLOCK);
            end
            else if (r < 92)
                send_write(OFFSET_W'($urandom_range(0, 4095)), $urandom());
            else
            begin
                case ($urandom_range(0, 2))
                    0: d = KEY_LOCK;
                    1: d = KEY_UNLOCK;
                    default: d = $urandom();
                endcase
                send_write(OFF_LOCK, d);
            end
        end
        @(negedge clk) in_ch.valid <= 1'b0;

        // Drain, then a few idle cycles to catch stray results
        drain = 0;
        while (status_q.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (status_q.size() != 0)
            report_mismatch($sformatf("%0d status results never arrived", status_q.size()));

        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- watchdog_timer_registers_unit.f -----
rtl/core/wdt_pkg.sv
rtl/core/wdt_if.sv
rtl/core/watchdog_timer_registers_unit.sv
rtl/core/wdt_checker.sv
tb/tb_watchdog_timer_registers_unit.sv
